@@ rtl/clg_pkg.sv @@
// Shared state encodings and fixed constants for the 3D LUT color grader.
`timescale 1ns / 1ps
package clg_pkg;

  // Front end sequencer: capture, the per-axis split for pixels (multiply, divide, weight, base), then push or drop.
  typedef enum logic [2:0] {
    FE_IDLE,
    FE_MUL,
    FE_DIV,
    FE_WGT,
    FE_BASE,
    FE_PUSH,
    FE_DROP
  } fe_state_t;

  // Back end sequencer: corner fetch loop, drain, scale and blend.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FETCH,
    BK_DRAIN,
    BK_GRADE,
    BK_BLEND
  } bk_state_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LUT_SIDE     = 2'd0;
  localparam logic [1:0] CFG_BLEND_AMOUNT = 2'd1;

  // Request kinds.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // x / 255 == (x * RECIP_255) >> RECIP_SHIFT for every x below 66052.
  localparam logic [31:0] RECIP_255   = 32'd32897;
  localparam int          RECIP_SHIFT = 23;

  localparam logic [12:0] Q_ONE = 13'd4096;
  localparam logic [8:0]  W_ONE = 9'd256;

endpackage

@@ rtl/clg_queue.sv @@
// Two-entry request queue between the front end and the back end.
`timescale 1ns / 1ps
module clg_queue #(
  parameter type job_t = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/clg_front.sv @@
// Front end: accepts requests, clamps loads and splits pixel channels into cell and weight.
`timescale 1ns / 1ps
module clg_front #(
  parameter int MAX_SIDE = 33,
  parameter type job_t = logic
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [5:0]  lut_side,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_entry_index,
  input  logic [12:0] in_entry_low_chan,
  input  logic [12:0] in_entry_mid_chan,
  input  logic [12:0] in_entry_high_chan,
  input  logic [31:0] in_pixel_in,
  output logic        push_valid,
  input  logic        push_ready,
  output job_t        push_data
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int IW    = $clog2(MAX_SIDE);
  localparam int PW    = $clog2(255 * (MAX_SIDE - 1) + 1);

  clg_pkg::fe_state_t state_r, state_nxt;
  job_t               job_r, job_nxt;
  logic [SW-1:0]      side_r, side_nxt, side_eff, sm1;
  logic [PW-1:0]      p_r [3];
  logic [PW-1:0]      p_nxt [3];
  logic [IW-1:0]      i0_r [3];
  logic [IW-1:0]      i0_nxt [3];
  logic [IW-1:0]      i1_r [3];
  logic [IW-1:0]      i1_nxt [3];
  logic [7:0]         rem_r [3];
  logic [7:0]         rem_nxt [3];
  logic [AW-1:0]      bs0_r, bs0_nxt, bs1_r, bs1_nxt;

  assign push_data  = job_r;
  assign sm1        = side_r - SW'(1);

  always_comb begin
    if (lut_side < 6'd2) begin
      side_eff = SW'(2);
    end else if ({1'b0, lut_side} > 7'(MAX_SIDE)) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = SW'(lut_side);
    end
  end

  always_comb begin
    logic [31:0] prod;
    logic [31:0] q;
    logic [31:0] wv;
    state_nxt  = state_r;
    job_nxt    = job_r;
    side_nxt   = side_r;
    bs0_nxt    = bs0_r;
    bs1_nxt    = bs1_r;
    in_ready   = 1'b0;
    push_valid = 1'b0;
    for (int k = 0; k < 3; k++) begin
      p_nxt[k]   = p_r[k];
      i0_nxt[k]  = i0_r[k];
      i1_nxt[k]  = i1_r[k];
      rem_nxt[k] = rem_r[k];
    end
    prod = '0;
    q    = '0;
    wv   = '0;
    unique case (state_r)
      clg_pkg::FE_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          job_nxt.pixel = in_pixel_in;
          if (in_req_type == clg_pkg::REQ_PIXEL) begin
            job_nxt.is_pixel = 1'b1;
            side_nxt         = side_eff;
            state_nxt        = clg_pkg::FE_MUL;
          end else begin
            job_nxt.is_pixel  = 1'b0;
            job_nxt.load_addr = AW'(in_entry_index);
            job_nxt.c0 = (in_entry_low_chan > clg_pkg::Q_ONE) ? clg_pkg::Q_ONE
                                                                : in_entry_low_chan;
            job_nxt.c1 = (in_entry_mid_chan > clg_pkg::Q_ONE) ? clg_pkg::Q_ONE
                                                                : in_entry_mid_chan;
            job_nxt.c2 = (in_entry_high_chan > clg_pkg::Q_ONE) ? clg_pkg::Q_ONE
                                                                 : in_entry_high_chan;
            // Loads past the end of the table are dropped here.
            if (32'(in_entry_index) < 32'(DEPTH)) begin
              state_nxt = clg_pkg::FE_PUSH;
            end else begin
              state_nxt = clg_pkg::FE_DROP;
            end
          end
        end
      end
      clg_pkg::FE_MUL: begin
        for (int k = 0; k < 3; k++) begin
          p_nxt[k] = PW'(32'(job_r.pixel[8*k +: 8]) * 32'(sm1));
        end
        state_nxt = clg_pkg::FE_DIV;
      end
      clg_pkg::FE_DIV: begin
        for (int k = 0; k < 3; k++) begin
          prod = 32'(p_r[k]) * clg_pkg::RECIP_255;
          q    = prod >> clg_pkg::RECIP_SHIFT;
          rem_nxt[k] = 8'(32'(p_r[k]) - ((q << 8) - q));
          i0_nxt[k]  = (q > 32'(sm1)) ? IW'(sm1) : IW'(q);
          i1_nxt[k]  = (q >= 32'(sm1)) ? IW'(sm1) : IW'(q + 32'd1);
        end
        state_nxt = clg_pkg::FE_WGT;
      end
      clg_pkg::FE_WGT: begin
        wv = ((32'(rem_r[0]) << 8) + 32'd127) * clg_pkg::RECIP_255;
        job_nxt.w0 = 8'(wv >> clg_pkg::RECIP_SHIFT);
        wv = ((32'(rem_r[1]) << 8) + 32'd127) * clg_pkg::RECIP_255;
        job_nxt.w1 = 8'(wv >> clg_pkg::RECIP_SHIFT);
        wv = ((32'(rem_r[2]) << 8) + 32'd127) * clg_pkg::RECIP_255;
        job_nxt.w2 = 8'(wv >> clg_pkg::RECIP_SHIFT);
        job_nxt.r0 = AW'(i0_r[0]);
        job_nxt.r1 = AW'(i1_r[0]);
        job_nxt.g0 = AW'(32'(i0_r[1]) * 32'(side_r));
        job_nxt.g1 = AW'(32'(i1_r[1]) * 32'(side_r));
        bs0_nxt    = AW'(32'(i0_r[2]) * 32'(side_r));
        bs1_nxt    = AW'(32'(i1_r[2]) * 32'(side_r));
        state_nxt  = clg_pkg::FE_BASE;
      end
      clg_pkg::FE_BASE: begin
        job_nxt.b0 = AW'(32'(bs0_r) * 32'(side_r));
        job_nxt.b1 = AW'(32'(bs1_r) * 32'(side_r));
        state_nxt  = clg_pkg::FE_PUSH;
      end
      clg_pkg::FE_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = clg_pkg::FE_IDLE;
        end
      end
      clg_pkg::FE_DROP: begin
        state_nxt = clg_pkg::FE_IDLE;
      end
      default: begin
        state_nxt = clg_pkg::FE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clg_pkg::FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    side_r <= side_nxt;
    bs0_r  <= bs0_nxt;
    bs1_r  <= bs1_nxt;
    for (int k = 0; k < 3; k++) begin
      p_r[k]   <= p_nxt[k];
      i0_r[k]  <= i0_nxt[k];
      i1_r[k]  <= i1_nxt[k];
      rem_r[k] <= rem_nxt[k];
    end
  end

endmodule

@@ rtl/clg_back.sv @@
// Back end: table memory, eight-corner fetch and accumulate, scaling and blend.
`timescale 1ns / 1ps
module clg_back #(
  parameter int MAX_SIDE = 33,
  parameter type job_t = logic
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [8:0]  blend_amount,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  job_t        pop_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_out
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic [38:0]        lut_mem [DEPTH];
  logic [38:0]        rd_data_r;
  logic               mem_we, mem_re;
  logic [AW-1:0]      rd_addr;

  clg_pkg::bk_state_t state_r, state_nxt;
  job_t               job_r, job_nxt;
  logic [2:0]         cnt_r, cnt_nxt;

  // Weight pipeline: stage 1 waits on the memory read, stage 2 accumulates.
  logic               s1_v_r, s2_v_r;
  logic [16:0]        w01_r, w01_nxt;
  logic [8:0]         wa2_r, wa2_nxt;
  logic [24:0]        wt_r;
  logic [38:0]        dat_r;
  logic [36:0]        acc_r [3];
  logic               acc_clr;
  logic [7:0]         gr_r [3];
  logic [7:0]         gr_nxt [3];
  logic               out_valid_r, out_load;
  logic [31:0]        out_pix_r, out_pix_nxt;

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;

  function automatic logic [8:0] axis_wt(input logic hi, input logic [7:0] w);
    return hi ? {1'b0, w} : (clg_pkg::W_ONE - {1'b0, w});
  endfunction

  function automatic logic [7:0] blend_byte(input logic [7:0] orig, input logic [7:0] gr,
                                            input logic [8:0] a);
    logic signed [19:0] v;
    logic signed [19:0] r;
    v = $signed({12'd0, orig}) * ($signed(20'd256) - $signed({11'd0, a}))
        + $signed({12'd0, gr}) * $signed({11'd0, a});
    r = (v + 20'sd128) >>> 8;
    if (v <= 20'sd0) begin
      return 8'd0;
    end else if (r > 20'sd255) begin
      return 8'd255;
    end
    return r[7:0];
  endfunction

  always_comb begin
    rd_addr = (cnt_r[2] ? job_r.b1 : job_r.b0) + (cnt_r[1] ? job_r.g1 : job_r.g0)
            + (cnt_r[0] ? job_r.r1 : job_r.r0);
    w01_nxt = 17'(axis_wt(cnt_r[0], job_r.w0)) * 17'(axis_wt(cnt_r[1], job_r.w1));
    wa2_nxt = axis_wt(cnt_r[2], job_r.w2);
  end

  always_comb begin
    logic [44:0] t;
    state_nxt   = state_r;
    job_nxt     = job_r;
    cnt_nxt     = cnt_r;
    pop_ready   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    acc_clr     = 1'b0;
    out_load    = 1'b0;
    out_pix_nxt = out_pix_r;
    t           = '0;
    for (int k = 0; k < 3; k++) begin
      gr_nxt[k] = gr_r[k];
    end
    unique case (state_r)
      clg_pkg::BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_data.is_pixel) begin
            job_nxt   = pop_data;
            cnt_nxt   = 3'd0;
            acc_clr   = 1'b1;
            state_nxt = clg_pkg::BK_FETCH;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      clg_pkg::BK_FETCH: begin
        mem_re  = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = clg_pkg::BK_DRAIN;
        end
      end
      clg_pkg::BK_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = clg_pkg::BK_GRADE;
        end
      end
      clg_pkg::BK_GRADE: begin
        for (int k = 0; k < 3; k++) begin
          t = (45'(acc_r[k]) << 8) - 45'(acc_r[k]);
          gr_nxt[k] = ((t >> 36) > 45'd255) ? 8'd255 : 8'(t >> 36);
        end
        state_nxt = clg_pkg::BK_BLEND;
      end
      clg_pkg::BK_BLEND: begin
        if (!out_valid_r || out_ready) begin
          out_load    = 1'b1;
          out_pix_nxt = {job_r.pixel[31:24],
                         blend_byte(job_r.pixel[23:16], gr_r[2], blend_amount),
                         blend_byte(job_r.pixel[15:8], gr_r[1], blend_amount),
                         blend_byte(job_r.pixel[7:0], gr_r[0], blend_amount)};
          state_nxt   = clg_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = clg_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lut_mem[pop_data.load_addr] <= {pop_data.c2, pop_data.c1, pop_data.c0};
    end
    if (mem_re) begin
      rd_data_r <= lut_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clg_pkg::BK_IDLE;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= mem_re;
      s2_v_r  <= s1_v_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    cnt_r     <= cnt_nxt;
    w01_r     <= w01_nxt;
    wa2_r     <= wa2_nxt;
    wt_r      <= 25'(w01_r) * 25'(wa2_r);
    dat_r     <= rd_data_r;
    out_pix_r <= out_pix_nxt;
    for (int k = 0; k < 3; k++) begin
      gr_r[k] <= gr_nxt[k];
      if (acc_clr) begin
        acc_r[k] <= '0;
      end else if (s2_v_r) begin
        acc_r[k] <= acc_r[k] + 37'(wt_r) * 37'(dat_r[13*k +: 13]);
      end
    end
  end

endmodule

@@ rtl/cube_lut_trilinear_grade.sv @@
// Top level of the 3D LUT trilinear color grader.
// Usage:
//   Requests arrive on the in_ channel (valid/ready). A load request writes
//   one table entry of three Q1.12 components at in_entry_index; it gives no
//   result. A pixel request grades in_pixel_in and gives one out_pixel_out
//   with alpha unchanged.
//   The cfg_ channel writes lut_side (index 0) and blend_amount (index 1);
//   cfg_ready is always high. Write it only while no request is in flight.
//   A pixel goes through the front end (multiply, divide by 255, weight,
//   table offset, push), the queue and the back end, where eight corner
//   reads go through the single table read port one per cycle, followed
//   by a pipeline drain, scaling and blend.
//   Front and back overlap through a two-entry queue, so the front end can
//   prepare the next request while the back end grades a pixel; the front
//   end takes a new request only after it has pushed or dropped the last.
//   Reset clears all control state and the output valid; the table content is
//   undefined until loaded. When out_ready is low the result waits in the
//   output register while the front end keeps taking and preparing requests
//   until the queue is full.
`timescale 1ns / 1ps
module cube_lut_trilinear_grade #(
  parameter int MAX_SIDE = 33
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_entry_index,
  input  logic [12:0] in_entry_low_chan,
  input  logic [12:0] in_entry_mid_chan,
  input  logic [12:0] in_entry_high_chan,
  input  logic [31:0] in_pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  typedef struct packed {
    logic          is_pixel;
    logic [31:0]   pixel;
    logic [AW-1:0] load_addr;
    logic [12:0]   c0;
    logic [12:0]   c1;
    logic [12:0]   c2;
    logic [7:0]    w0;
    logic [7:0]    w1;
    logic [7:0]    w2;
    logic [AW-1:0] r0;
    logic [AW-1:0] r1;
    logic [AW-1:0] g0;
    logic [AW-1:0] g1;
    logic [AW-1:0] b0;
    logic [AW-1:0] b1;
  } job_t;

  logic [5:0] lut_side_r;
  logic [8:0] blend_amount_r;
  logic       q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  job_t       q_push_data, q_pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lut_side_r     <= 6'd33;
      blend_amount_r <= 9'd256;
    end else if (cfg_valid) begin
      if (cfg_index == clg_pkg::CFG_LUT_SIDE) begin
        lut_side_r <= cfg_data[5:0];
      end else if (cfg_index == clg_pkg::CFG_BLEND_AMOUNT) begin
        blend_amount_r <= cfg_data;
      end
    end
  end

  clg_front #(.MAX_SIDE(MAX_SIDE), .job_t(job_t)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .lut_side           (lut_side_r),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_entry_index     (in_entry_index),
    .in_entry_low_chan  (in_entry_low_chan),
    .in_entry_mid_chan  (in_entry_mid_chan),
    .in_entry_high_chan (in_entry_high_chan),
    .in_pixel_in        (in_pixel_in),
    .push_valid         (q_push_valid),
    .push_ready         (q_push_ready),
    .push_data          (q_push_data)
  );

  clg_queue #(.job_t(job_t)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  clg_back #(.MAX_SIDE(MAX_SIDE), .job_t(job_t)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .blend_amount  (blend_amount_r),
    .pop_valid     (q_pop_valid),
    .pop_ready     (q_pop_ready),
    .pop_data      (q_pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out)
  );

endmodule

@@ rtl/clg_checker.sv @@
// Port-level checker for the grader, bound to the top level.
`timescale 1ns / 1ps
module clg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel_out,
  input logic        cfg_ready
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The front end works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken back to back");

  // Register writes never stall.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind cube_lut_trilinear_grade clg_checker u_clg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pixel_out (out_pixel_out),
  .cfg_ready     (cfg_ready)
);
